FILE: hw/rtl/wffs_pkg.sv
`default_nettype none
package wffs_pkg;

    localparam int FLOWS_DEF         = 16;
    localparam int JOBS_PER_FLOW_DEF = 16;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_SRV = 2'd1,
        MODE_RM  = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RSV   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_ACT,
        CELL_PUSH,
        CELL_POP,
        CELL_SETCNT
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] weight;
    } cell_cmd_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] weight;
        logic [31:0] handle;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_CHK,
        S_SEARCH,
        S_ENQ_WR,
        S_SRV_RD,
        S_SRV_DATA,
        S_RM_FLOW,
        S_RM_RD,
        S_RM_DATA
    } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/weighted_fair_flow_scheduler_core.sv
`default_nettype none
// channel   | signals                                     | handshake
// ----------+---------------------------------------------+--------------------------
// command   | mode flow job_id job_weight job_handle      | start high, busy low
// result    | status out_flow out_job_id out_job_weight   | done strobe, one cycle
//           | out_job_handle removed_count                |
// enqueue: an active flow goes check then write; an idle one runs the chain min search first.
// serve: the min search walks the row of flow cells, one cell a cycle; then the head job is read.
// remove: visits every flow, reading and writing back each queued job (one job store port each way).
// reset clears all flow cells at once; the job store needs no clearing.
// done marks each result beat for one cycle; the receiver cannot stall.
module weighted_fair_flow_scheduler_core #(
    parameter int FLOWS         = wffs_pkg::FLOWS_DEF,
    parameter int JOBS_PER_FLOW = wffs_pkg::JOBS_PER_FLOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [3:0]  flow,
    input  wire logic [31:0] job_id,
    input  wire logic [15:0] job_weight,
    input  wire logic [31:0] job_handle,
    output logic             done,
    output logic [1:0]       status,
    output logic [3:0]       out_flow,
    output logic [31:0]      out_job_id,
    output logic [15:0]      out_job_weight,
    output logic [31:0]      out_job_handle,
    output logic [8:0]       removed_count
);
    import wffs_pkg::*;

    localparam int FW    = $clog2(FLOWS);
    localparam int HW    = (JOBS_PER_FLOW > 1) ? $clog2(JOBS_PER_FLOW) : 1;
    localparam int CW    = $clog2(JOBS_PER_FLOW + 1);
    localparam int DEPTH = FLOWS * JOBS_PER_FLOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(FLOWS + 1);

    logic          act_a [FLOWS];
    logic [31:0]   wgt_a [FLOWS];
    logic [CW-1:0] cnt_a [FLOWS];
    logic [HW-1:0] head_a [FLOWS];
    logic          cv_a  [FLOWS+1];
    logic [FW-1:0] ci_a  [FLOWS+1];
    logic [31:0]   cw_a  [FLOWS+1];

    cell_cmd_t cmd;

    state_t        state_reg, state_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [1:0]    mode_reg, mode_next;
    logic [FW-1:0] sel_reg, sel_next;
    logic          fok_reg, fok_next;
    logic [31:0]   id_reg, id_next;
    logic [15:0]   jw_reg, jw_next;
    logic [31:0]   jh_reg, jh_next;
    logic [SW-1:0] scnt_reg, scnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [8:0]    rm_reg, rm_next;
    logic [1:0]    st_reg, st_next;
    logic [3:0]    of_reg, of_next;
    logic [31:0]   oid_reg, oid_next;
    logic [15:0]   ow_reg, ow_next;
    logic [31:0]   oh_reg, oh_next;
    logic [8:0]    orm_reg, orm_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, slot_addr;
    job_t          ram_wdata, ram_rdata;
    logic [CW-1:0] slot_k;
    logic [CW:0]   slot_sum;
    logic [CW-1:0] kept_set;

    assign cv_a[0] = 1'b0;
    assign ci_a[0] = '0;
    assign cw_a[0] = '0;

    for (genvar g = 0; g < FLOWS; g++)
    begin : g_cell
        wffs_cell #(
            .FLOWS(FLOWS),
            .JOBS_PER_FLOW(JOBS_PER_FLOW),
            .IDX(g)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .cmd(cmd),
            .sel(sel_reg),
            .kept(kept_set),
            .cin_valid(cv_a[g]),
            .cin_idx(ci_a[g]),
            .cin_weight(cw_a[g]),
            .active(act_a[g]),
            .weight(wgt_a[g]),
            .count(cnt_a[g]),
            .head(head_a[g]),
            .cout_valid(cv_a[g+1]),
            .cout_idx(ci_a[g+1]),
            .cout_weight(cw_a[g+1])
        );
    end

    wffs_ram #(
        .WIDTH($bits(job_t)),
        .DEPTH(DEPTH)
    ) u_store (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // slot of job k in the selected flow's ring
    always_comb
    begin
        slot_sum = (CW+1)'(head_a[sel_reg]) + (CW+1)'(slot_k);
        if (slot_sum >= (CW+1)'(JOBS_PER_FLOW))
        begin
            slot_sum = slot_sum - (CW+1)'(JOBS_PER_FLOW);
        end
        slot_addr = AW'(sel_reg) * AW'(JOBS_PER_FLOW) + AW'(slot_sum);
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        mode_next  = mode_reg;
        sel_next   = sel_reg;
        fok_next   = fok_reg;
        id_next    = id_reg;
        jw_next    = jw_reg;
        jh_next    = jh_reg;
        scnt_next  = scnt_reg;
        k_next     = k_reg;
        kept_next  = kept_reg;
        rm_next    = rm_reg;
        st_next    = st_reg;
        of_next    = of_reg;
        oid_next   = oid_reg;
        ow_next    = ow_reg;
        oh_next    = oh_reg;
        orm_next   = orm_reg;
        cmd.op     = CELL_NOP;
        cmd.weight = {16'b0, jw_reg};
        kept_set   = kept_reg;
        slot_k     = k_reg;
        ram_we     = 1'b0;
        ram_wdata  = job_t'({id_reg, jw_reg, jh_reg});
        ram_waddr  = slot_addr;
        ram_raddr  = slot_addr;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    id_next   = job_id;
                    jw_next   = job_weight;
                    jh_next   = job_handle;
                    fok_next  = ({5'b0, flow} < 9'(FLOWS));
                    sel_next  = FW'(flow);
                    scnt_next = SW'(FLOWS);
                    st_next   = STAT_DONE;
                    of_next   = '0;
                    oid_next  = '0;
                    ow_next   = '0;
                    oh_next   = '0;
                    orm_next  = '0;
                    case (mode_t'(mode))
                        MODE_ENQ:
                        begin
                            busy_next  = 1'b1;
                            state_next = S_ENQ_CHK;
                        end
                        MODE_SRV:
                        begin
                            busy_next  = 1'b1;
                            state_next = S_SEARCH;
                        end
                        MODE_RM:
                        begin
                            busy_next  = 1'b1;
                            sel_next   = '0;
                            rm_next    = '0;
                            state_next = S_RM_FLOW;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ENQ_CHK:
            begin
                if (!fok_reg || cnt_a[sel_reg] >= CW'(JOBS_PER_FLOW))
                begin
                    st_next    = STAT_FULL;
                    done_next  = 1'b1;
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (act_a[sel_reg])
                begin
                    state_next = S_ENQ_WR;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                scnt_next = scnt_reg - SW'(1);
                if (scnt_reg == SW'(1))
                begin
                    if (mode_reg == MODE_ENQ)
                    begin
                        cmd.op     = CELL_ACT;
                        cmd.weight = cv_a[FLOWS] ? cw_a[FLOWS] : 32'b0;
                        state_next = S_ENQ_WR;
                    end
                    else if (!cv_a[FLOWS])
                    begin
                        st_next    = STAT_EMPTY;
                        done_next  = 1'b1;
                        busy_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sel_next   = ci_a[FLOWS];
                        state_next = S_SRV_RD;
                    end
                end
            end
            S_ENQ_WR:
            begin
                slot_k     = cnt_a[sel_reg];
                ram_we     = 1'b1;
                cmd.op     = CELL_PUSH;
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            S_SRV_RD:
            begin
                slot_k     = '0;
                state_next = S_SRV_DATA;
            end
            S_SRV_DATA:
            begin
                cmd.op     = CELL_POP;
                cmd.weight = {16'b0, ram_rdata.weight};
                of_next    = 4'(sel_reg);
                oid_next   = ram_rdata.id;
                ow_next    = ram_rdata.weight;
                oh_next    = ram_rdata.handle;
                done_next  = 1'b1;
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
            S_RM_FLOW:
            begin
                k_next    = '0;
                kept_next = '0;
                if (act_a[sel_reg])
                begin
                    state_next = S_RM_RD;
                end
                else if (sel_reg == FW'(FLOWS - 1))
                begin
                    orm_next   = rm_reg;
                    done_next  = 1'b1;
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sel_next = sel_reg + FW'(1);
                end
            end
            S_RM_RD:
            begin
                slot_k     = k_reg;
                state_next = S_RM_DATA;
            end
            S_RM_DATA:
            begin
                slot_k    = kept_reg;
                ram_wdata = ram_rdata;
                if (ram_rdata.id == id_reg)
                begin
                    if (rm_reg != 9'h1FF)
                    begin
                        rm_next = rm_reg + 9'd1;
                    end
                    kept_set = kept_reg;
                end
                else
                begin
                    ram_we   = 1'b1;
                    kept_set = kept_reg + CW'(1);
                end
                kept_next = kept_set;
                k_next    = k_reg + CW'(1);
                if (k_reg + CW'(1) == cnt_a[sel_reg])
                begin
                    cmd.op = CELL_SETCNT;
                    if (sel_reg == FW'(FLOWS - 1))
                    begin
                        orm_next   = rm_next;
                        done_next  = 1'b1;
                        busy_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sel_next   = sel_reg + FW'(1);
                        state_next = S_RM_FLOW;
                    end
                end
                else
                begin
                    state_next = S_RM_RD;
                end
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        sel_reg  <= sel_next;
        fok_reg  <= fok_next;
        id_reg   <= id_next;
        jw_reg   <= jw_next;
        jh_reg   <= jh_next;
        scnt_reg <= scnt_next;
        k_reg    <= k_next;
        kept_reg <= kept_next;
        rm_reg   <= rm_next;
        st_reg   <= st_next;
        of_reg   <= of_next;
        oid_reg  <= oid_next;
        ow_reg   <= ow_next;
        oh_reg   <= oh_next;
        orm_reg  <= orm_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign status         = st_reg;
    assign out_flow       = of_reg;
    assign out_job_id     = oid_reg;
    assign out_job_weight = ow_reg;
    assign out_job_handle = oh_reg;
    assign removed_count  = orm_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != STAT_RSV)
        else $error("reserved status code");

    a_rm_data_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RM_DATA |-> $past(state_reg) == S_RM_RD)
        else $error("store data used without a read");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> scnt_reg != '0)
        else $error("search counter ran out");
endmodule
`default_nettype wire

FILE: hw/rtl/wffs_ram.sv
`default_nettype none
module wffs_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/wffs_cell.sv
`default_nettype none
module wffs_cell #(
    parameter int FLOWS         = 16,
    parameter int JOBS_PER_FLOW = 16,
    parameter int IDX           = 0,
    localparam int FW = $clog2(FLOWS),
    localparam int HW = (JOBS_PER_FLOW > 1) ? $clog2(JOBS_PER_FLOW) : 1,
    localparam int CW = $clog2(JOBS_PER_FLOW + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wffs_pkg::cell_cmd_t      cmd,
    input  wire logic [FW-1:0]       sel,
    input  wire logic [CW-1:0]       kept,
    input  wire logic                cin_valid,
    input  wire logic [FW-1:0]       cin_idx,
    input  wire logic [31:0]         cin_weight,
    output logic                     active,
    output logic [31:0]              weight,
    output logic [CW-1:0]            count,
    output logic [HW-1:0]            head,
    output logic                     cout_valid,
    output logic [FW-1:0]            cout_idx,
    output logic [31:0]              cout_weight
);
    import wffs_pkg::*;

    logic          active_reg, active_next;
    logic [31:0]   weight_reg, weight_next;
    logic [CW-1:0] count_reg, count_next;
    logic [HW-1:0] head_reg, head_next;
    logic          cv_reg, cv_next;
    logic [FW-1:0] ci_reg, ci_next;
    logic [31:0]   cw_reg, cw_next;
    logic [32:0]   sum;
    logic [HW:0]   head_inc;
    logic          mine;

    always_comb
    begin
        mine        = (sel == FW'(IDX));
        active_next = active_reg;
        weight_next = weight_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        sum         = {1'b0, weight_reg} + {17'b0, cmd.weight[15:0]};
        head_inc    = {1'b0, head_reg} + (HW+1)'(1);
        if (mine)
        begin
            case (cmd.op)
                CELL_ACT:
                begin
                    active_next = 1'b1;
                    weight_next = cmd.weight;
                    count_next  = '0;
                    head_next   = '0;
                end
                CELL_PUSH:
                begin
                    count_next = count_reg + CW'(1);
                end
                CELL_POP:
                begin
                    weight_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    count_next  = count_reg - CW'(1);
                    head_next   = (head_inc == (HW+1)'(JOBS_PER_FLOW)) ? '0 : head_inc[HW-1:0];
                    if (count_reg == CW'(1))
                    begin
                        active_next = 1'b0;
                        count_next  = '0;
                        head_next   = '0;
                    end
                end
                CELL_SETCNT:
                begin
                    count_next = kept;
                    if (kept == '0)
                    begin
                        active_next = 1'b0;
                        head_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        // strict compare keeps the lower flow on ties
        if (active_reg && (!cin_valid || weight_reg < cin_weight))
        begin
            cv_next = 1'b1;
            ci_next = FW'(IDX);
            cw_next = weight_reg;
        end
        else
        begin
            cv_next = cin_valid;
            ci_next = cin_idx;
            cw_next = cin_weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            weight_reg <= '0;
            count_reg  <= '0;
            head_reg   <= '0;
            cv_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            weight_reg <= weight_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            cv_reg     <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg <= ci_next;
        cw_reg <= cw_next;
    end

    assign active      = active_reg;
    assign weight      = weight_reg;
    assign count       = count_reg;
    assign head        = head_reg;
    assign cout_valid  = cv_reg;
    assign cout_idx    = ci_reg;
    assign cout_weight = cw_reg;
endmodule
`default_nettype wire

FILE: tb/weighted_fair_flow_scheduler_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module weighted_fair_flow_scheduler_checker
    import wffs_pkg::*;
#(
    parameter int FLOWS         = FLOWS_DEF,
    parameter int JOBS_PER_FLOW = JOBS_PER_FLOW_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  mode,
    input  wire logic [3:0]  flow,
    input  wire logic [31:0] job_id,
    input  wire logic [15:0] job_weight,
    input  wire logic [31:0] job_handle,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [3:0]  out_flow,
    input  wire logic [31:0] out_job_id,
    input  wire logic [15:0] out_job_weight,
    input  wire logic [31:0] out_job_handle,
    input  wire logic [8:0]  removed_count,
    output int               fail_count,
    output int               pending,
    output int               served_jobs,
    output int               removed_jobs,
    output int               full_hits,
    output int               empty_hits
);

    typedef struct packed {
        status_t     st;
        logic [3:0]  fl;
        logic [31:0] id;
        logic [15:0] wt;
        logic [31:0] hd;
        logic [8:0]  rc;
    } answer_t;

    // scheduler image: each flow keeps its jobs as a plain queue in order
    bit          act_q[FLOWS];
    logic [31:0] acc_q[FLOWS];
    job_t        fifo_q[FLOWS][$];
    answer_t     answer_q[$];

    function automatic int least_flow();
        int best;
        best = FLOWS;
        for (int f = 0; f < FLOWS; f++)
            if (act_q[f] && (best == FLOWS || acc_q[f] < acc_q[best]))
                best = f;
        return best;
    endfunction

    task automatic schedule(input mode_t m, input logic [3:0] fl, input logic [31:0] id,
                            input logic [15:0] wt, input logic [31:0] hd);
        answer_t a;
        int      f;
        int      cnt;
        job_t    j;
        job_t    keep[$];
        logic [32:0] sum;
        a = '0;
        a.st = STAT_DONE;
        case (m)
            MODE_ENQ:
            begin
                if (fl >= FLOWS || fifo_q[fl].size() >= JOBS_PER_FLOW)
                    a.st = STAT_FULL;
                else
                begin
                    if (!act_q[fl])
                    begin
                        f = least_flow();
                        acc_q[fl] = (f == FLOWS) ? 32'd0 : acc_q[f];
                        act_q[fl] = 1'b1;
                    end
                    j.id = id;
                    j.weight = wt;
                    j.handle = hd;
                    fifo_q[fl] = {fifo_q[fl], j};
                end
            end
            MODE_SRV:
            begin
                f = least_flow();
                if (f == FLOWS)
                    a.st = STAT_EMPTY;
                else
                begin
                    j = fifo_q[f][0];
                    fifo_q[f].delete(0);
                    sum = {1'b0, acc_q[f]} + j.weight;
                    acc_q[f] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (fifo_q[f].size() == 0)
                        act_q[f] = 1'b0;
                    a.fl = f[3:0];
                    a.id = j.id;
                    a.wt = j.weight;
                    a.hd = j.handle;
                end
            end
            MODE_RM:
            begin
                cnt = 0;
                for (int g = 0; g < FLOWS; g++)
                begin
                    if (!act_q[g])
                        continue;
                    keep = {};
                    foreach (fifo_q[g][k])
                        if (fifo_q[g][k].id == id)
                            cnt++;
                        else
                            keep = {keep, fifo_q[g][k]};
                    fifo_q[g] = keep;
                    if (keep.size() == 0)
                        act_q[g] = 1'b0;
                end
                a.rc = (cnt > 511) ? 9'd511 : cnt[8:0];
            end
            default: ;
        endcase
        answer_q = {answer_q, a};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t e;
        answer_t g;
        if (!rst_n)
        begin
            for (int f = 0; f < FLOWS; f++)
            begin
                act_q[f] = 1'b0;
                acc_q[f] = '0;
                fifo_q[f] = {};
            end
            answer_q = {};
            fail_count <= 0;
            pending <= 0;
            served_jobs <= 0;
            removed_jobs <= 0;
            full_hits <= 0;
            empty_hits <= 0;
        end
        else
        begin
            // the result beat is checked before a command in the same edge is applied
            if (done)
            begin
                g.st = status_t'(status);
                g.fl = out_flow;
                g.id = out_job_id;
                g.wt = out_job_weight;
                g.hd = out_job_handle;
                g.rc = removed_count;
                if (answer_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: %p", $time, g);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = answer_q[0];
                    answer_q.delete(0);
                    if (g !== e)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch expected %p actual %p", $time, e, g);
                        fail_count <= fail_count + 1;
                    end
                    if (e.st == STAT_FULL)
                        full_hits <= full_hits + 1;
                    if (e.st == STAT_EMPTY)
                        empty_hits <= empty_hits + 1;
                    if (e.st == STAT_DONE && e.id != 0 || e.hd != 0)
                        served_jobs <= served_jobs + 1;
                    removed_jobs <= removed_jobs + e.rc;
                end
            end
            if (start && !busy)
                schedule(mode_t'(mode), flow, job_id, job_weight, job_handle);
            pending <= answer_q.size();
        end
    end

endmodule
`default_nettype wire

FILE: tb/weighted_fair_flow_scheduler_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module weighted_fair_flow_scheduler_core_tb;
    import wffs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [3:0]  flow;
    logic [31:0] job_id;
    logic [15:0] job_weight;
    logic [31:0] job_handle;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  out_flow;
    logic [31:0] out_job_id;
    logic [15:0] out_job_weight;
    logic [31:0] out_job_handle;
    logic [8:0]  removed_count;
    int          fail_count;
    int          pending;
    int          served_jobs;
    int          removed_jobs;
    int          full_hits;
    int          empty_hits;
    int          issued;

    weighted_fair_flow_scheduler_core DUT (.*);

    weighted_fair_flow_scheduler_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hand one command beat over, after a random idle gap that may be none
    task automatic issue(input mode_t m, input logic [3:0] fl, input logic [31:0] id,
                         input logic [15:0] wt, input logic [31:0] hd);
        int gap;
        gap = $urandom_range(3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        flow <= fl;
        job_id <= id;
        job_weight <= wt;
        job_handle <= hd;
        do
            @(posedge clk);
        while (busy);
        issued++;
    endtask

    // ids come from a small pool so removes hit often, plus some wide values
    function automatic logic [31:0] pick_id();
        return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
    endfunction

    initial
    begin
        int roll;
        int wait_cnt;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ENQ;
        flow = '0;
        job_id = '0;
        job_weight = '0;
        job_handle = '0;
        issued = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty serve, extremes, full flow, remove, unused mode
        issue(MODE_SRV, 4'd0, '0, '0, '0);
        issue(MODE_ENQ, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(MODE_ENQ, 4'd0, 32'd0, 16'd0, 32'd0);
        issue(MODE_NOP, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 17; k++)
            issue(MODE_ENQ, 4'd3, 32'd5, 16'hFFFF, 32'(k));
        issue(MODE_SRV, 4'd0, '0, '0, '0);
        issue(MODE_SRV, 4'd0, '0, '0, '0);
        issue(MODE_RM, 4'd0, 32'd5, '0, '0);
        issue(MODE_RM, 4'd0, 32'hFFFF_FFFF, '0, '0);
        issue(MODE_SRV, 4'd0, '0, '0, '0);
        issue(MODE_SRV, 4'd0, '0, '0, '0);

        // random: mostly enqueue and serve, some removes and idle commands
        for (int n = 0; n < 600; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 50)
                issue(MODE_ENQ, 4'($urandom), pick_id(),
                      ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom),
                      $urandom);
            else if (roll < 88)
                issue(MODE_SRV, 4'($urandom), $urandom, 16'($urandom), $urandom);
            else if (roll < 97)
                issue(MODE_RM, 4'($urandom), pick_id(), 16'($urandom), $urandom);
            else
                issue(MODE_NOP, 4'($urandom), $urandom, 16'($urandom), $urandom);
        end
        start <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 10000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (100) @(posedge clk);
        $display("%0d commands: %0d jobs served, %0d removed, %0d full, %0d empty serves",
                 issued, served_jobs, removed_jobs, full_hits, empty_hits);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/wffs_pkg.sv
hw/rtl/wffs_ram.sv
hw/rtl/wffs_cell.sv
hw/rtl/weighted_fair_flow_scheduler_core.sv
tb/weighted_fair_flow_scheduler_checker.sv
tb/weighted_fair_flow_scheduler_core_tb.sv
